/* rtl/thermistor_table_thermometer_unit_macros.svh */
// Assertion macros for the thermistor thermometer checker.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef THERMISTOR_TABLE_THERMOMETER_UNIT_MACROS_SVH
`define THERMISTOR_TABLE_THERMOMETER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TTT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("thermometer check failed");

// Next-cycle implication, checked outside reset.
`define TTT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("thermometer check failed");

`endif

/* rtl/ttt_pkg.sv */
// Shared types, codes and the thermistor code table for the thermometer unit.
// No dependencies; every other file but the macro header refers to it by scoped names.
`timescale 1ns / 1ps

package ttt_pkg;

  localparam int TABLE_ENTRIES  = 131;
  localparam int SAMPLE_BITS    = 10;
  localparam int IDX_BITS       = $clog2(TABLE_ENTRIES);
  localparam int CENTI_BITS     = 13;
  localparam int TICK_BITS      = 16;
  localparam int DELTA_BITS     = 10;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_PRESS  = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_MEAS = 2'd1;
  localparam logic [1:0] MODE_DONE = 2'd2;

  localparam logic [1:0] FLAG_OK   = 2'd0;
  localparam logic [1:0] FLAG_LOW  = 2'd1;
  localparam logic [1:0] FLAG_HIGH = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_INTERVAL = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELTA    = CFG_INDEX_BITS'(1);

  localparam logic [SAMPLE_BITS-1:0] CODE_TOP    = SAMPLE_BITS'(989);
  localparam logic [SAMPLE_BITS-1:0] CODE_BOTTOM = SAMPLE_BITS'(731);

  localparam logic [CENTI_BITS-1:0] CENTI_BASE = CENTI_BITS'(3200);
  localparam logic [CENTI_BITS-1:0] CENTI_TOP  = CENTI_BITS'(4500);
  localparam logic [CENTI_BITS-1:0] CENTI_STEP = CENTI_BITS'(10);
  localparam logic [CENTI_BITS-1:0] CENTI_HALF = CENTI_BITS'(5);

  localparam logic [TICK_BITS-1:0]  INTERVAL_RESET = TICK_BITS'(6000);
  localparam logic [DELTA_BITS-1:0] DELTA_RESET    = DELTA_BITS'(4);

  // ADC code per 0.1 C step from 32.0 C down the table to 45.0 C, descending.
  localparam logic [SAMPLE_BITS-1:0] CODE_TABLE [0:TABLE_ENTRIES-1] = '{
    10'd989, 10'd987, 10'd985, 10'd983, 10'd981, 10'd979, 10'd977, 10'd975, 10'd973, 10'd971,
    10'd970, 10'd968, 10'd966, 10'd965, 10'd963, 10'd961, 10'd960, 10'd958, 10'd956, 10'd954,
    10'd953, 10'd951, 10'd949, 10'd948, 10'd946, 10'd944, 10'd941, 10'd939, 10'd937, 10'd935,
    10'd932, 10'd930, 10'd928, 10'd926, 10'd923, 10'd921, 10'd919, 10'd917, 10'd914, 10'd912,
    10'd910, 10'd908, 10'd906, 10'd903, 10'd901, 10'd899, 10'd897, 10'd895, 10'd892, 10'd890,
    10'd888, 10'd886, 10'd883, 10'd881, 10'd879, 10'd877, 10'd875, 10'd873, 10'd871, 10'd869,
    10'd868, 10'd867, 10'd866, 10'd865, 10'd864, 10'd863, 10'd860, 10'd857, 10'd855, 10'd852,
    10'd849, 10'd847, 10'd845, 10'd843, 10'd841, 10'd839, 10'd837, 10'd835, 10'd833, 10'd831,
    10'd829, 10'd827, 10'd825, 10'd823, 10'd821, 10'd819, 10'd817, 10'd815, 10'd813, 10'd811,
    10'd809, 10'd807, 10'd805, 10'd803, 10'd801, 10'd799, 10'd797, 10'd795, 10'd793, 10'd790,
    10'd788, 10'd785, 10'd783, 10'd781, 10'd779, 10'd777, 10'd775, 10'd773, 10'd772, 10'd770,
    10'd769, 10'd767, 10'd765, 10'd763, 10'd761, 10'd759, 10'd758, 10'd756, 10'd755, 10'd753,
    10'd751, 10'd749, 10'd747, 10'd745, 10'd743, 10'd741, 10'd739, 10'd737, 10'd735, 10'd733,
    10'd731
  };

  typedef struct packed {
    logic                      we;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    logic take_in;
    logic set_latest;
    logic enter_measure;
    logic leave_done;
    logic tick_inc;
    logic restart;
    logic start_live;
    logic start_held;
    logic step;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] mode;
    logic       tick_ge;
    logic       stable;
    logic       hit;
  } status_t;

endpackage

/* rtl/ttt_if.sv */
// Valid/ready channel interfaces: request input, result output, register writes.
// Widths come from ttt_pkg.
`timescale 1ns / 1ps

interface ttt_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [ttt_pkg::SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, kind, adc_sample, input ready);
  modport sink (input valid, kind, adc_sample, output ready);
endinterface

interface ttt_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     mode;
  logic                           live_valid;
  logic [ttt_pkg::CENTI_BITS-1:0] live_centi;
  logic [1:0]                     live_flag;
  logic                           held_valid;
  logic [ttt_pkg::CENTI_BITS-1:0] held_centi;

  modport source (output valid, mode, live_valid, live_centi, live_flag, held_valid,
                  held_centi, input ready);
  modport sink (input valid, mode, live_valid, live_centi, live_flag, held_valid,
                held_centi, output ready);
endinterface

interface ttt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ttt_pkg::CFG_INDEX_BITS-1:0] index;
  logic [ttt_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/ttt_ctrl.sv */
// Sequencer of the thermometer unit: takes a request, issues datapath commands,
// walks the table search and hands the result to the output register. Uses ttt_pkg.
`timescale 1ns / 1ps

module ttt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ttt_pkg::status_t status_i,
  output ttt_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take_in = in_valid_i;
      end
      ST_EXEC: begin
        unique case (status_i.kind)
          ttt_pkg::KIND_SAMPLE: begin
            cmd_o.set_latest = 1'b1;
            cmd_o.start_live = (status_i.mode == ttt_pkg::MODE_MEAS);
          end
          ttt_pkg::KIND_PRESS: begin
            cmd_o.enter_measure = (status_i.mode == ttt_pkg::MODE_WAIT);
            cmd_o.leave_done    = (status_i.mode == ttt_pkg::MODE_DONE);
          end
          ttt_pkg::KIND_TICK: begin
            if (status_i.mode == ttt_pkg::MODE_MEAS) begin
              if (!status_i.tick_ge) begin
                cmd_o.tick_inc = 1'b1;
              end else if (status_i.stable) begin
                cmd_o.start_held = 1'b1;
              end else begin
                cmd_o.restart = 1'b1;
              end
            end
          end
          default: begin
            // unknown kind: drop, still answer with the state
          end
        endcase
      end
      ST_SEARCH: begin
        cmd_o.commit = status_i.hit;
        cmd_o.step   = !status_i.hit;
      end
      ST_FINISH: begin
        cmd_o.load_out = !out_valid_q || out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          state_q <= (cmd_o.start_live || cmd_o.start_held) ? ST_SEARCH : ST_FINISH;
        end
        ST_SEARCH: begin
          if (status_i.hit) state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (cmd_o.load_out) state_q <= ST_IDLE;
        end
      endcase
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

/* rtl/ttt_datapath.sv */
// Datapath of the thermometer unit: registers, interval counter, stability test,
// one-entry-per-cycle table search and the output register. Uses ttt_pkg.
`timescale 1ns / 1ps

module ttt_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ttt_pkg::cfg_wr_t                 cfg_i,
  input  logic [1:0]                       in_kind_i,
  input  logic [ttt_pkg::SAMPLE_BITS-1:0]  in_sample_i,
  input  ttt_pkg::cmd_t                    cmd_i,
  output ttt_pkg::status_t                 status_o,
  output logic [1:0]                       mode_o,
  output logic                             live_valid_o,
  output logic [ttt_pkg::CENTI_BITS-1:0]   live_centi_o,
  output logic [1:0]                       live_flag_o,
  output logic                             held_valid_o,
  output logic [ttt_pkg::CENTI_BITS-1:0]   held_centi_o
);

  logic [ttt_pkg::TICK_BITS-1:0]   interval_q;
  logic [ttt_pkg::DELTA_BITS-1:0]  delta_q;
  logic [1:0]                      mode_q;
  logic [ttt_pkg::SAMPLE_BITS-1:0] latest_q;
  logic [ttt_pkg::SAMPLE_BITS-1:0] start_q;
  logic [ttt_pkg::TICK_BITS-1:0]   tick_q;
  logic                            live_valid_q;
  logic [ttt_pkg::CENTI_BITS-1:0]  live_centi_q;
  logic [1:0]                      live_flag_q;
  logic                            held_valid_q;
  logic [ttt_pkg::CENTI_BITS-1:0]  held_centi_q;

  // request and search registers, no reset needed
  logic [1:0]                      kind_q;
  logic [ttt_pkg::SAMPLE_BITS-1:0] sample_q;
  logic [ttt_pkg::SAMPLE_BITS-1:0] code_q;
  logic [ttt_pkg::IDX_BITS-1:0]    idx_q;
  logic [ttt_pkg::CENTI_BITS-1:0]  centi_q;
  logic                            tgt_held_q;

  logic [1:0]                      out_mode_q;
  logic                            out_live_valid_q;
  logic [ttt_pkg::CENTI_BITS-1:0]  out_live_centi_q;
  logic [1:0]                      out_live_flag_q;
  logic                            out_held_valid_q;
  logic [ttt_pkg::CENTI_BITS-1:0]  out_held_centi_q;

  logic [ttt_pkg::SAMPLE_BITS-1:0] tab_code;
  logic [ttt_pkg::SAMPLE_BITS-1:0] drop;
  logic                            clamp_low;
  logic                            clamp_high;
  logic [ttt_pkg::CENTI_BITS-1:0]  res_centi;
  logic [1:0]                      res_flag;

  assign tab_code   = ttt_pkg::CODE_TABLE[idx_q];
  assign clamp_low  = (code_q > ttt_pkg::CODE_TOP);
  assign clamp_high = (code_q < ttt_pkg::CODE_BOTTOM);
  assign drop       = start_q - latest_q;

  // first entry at or below the code: equal is exact, below means half a step back
  always_comb begin
    priority if (clamp_low) begin
      res_centi = ttt_pkg::CENTI_BASE;
      res_flag  = ttt_pkg::FLAG_LOW;
    end else if (clamp_high) begin
      res_centi = ttt_pkg::CENTI_TOP;
      res_flag  = ttt_pkg::FLAG_HIGH;
    end else if (tab_code == code_q) begin
      res_centi = centi_q;
      res_flag  = ttt_pkg::FLAG_OK;
    end else begin
      res_centi = centi_q - ttt_pkg::CENTI_HALF;
      res_flag  = ttt_pkg::FLAG_OK;
    end
  end

  assign status_o.kind    = kind_q;
  assign status_o.mode    = mode_q;
  assign status_o.tick_ge = (tick_q >= interval_q);
  assign status_o.stable  = (start_q >= latest_q) && (drop < delta_q);
  assign status_o.hit     = clamp_low || clamp_high || (tab_code <= code_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= ttt_pkg::INTERVAL_RESET;
      delta_q      <= ttt_pkg::DELTA_RESET;
      mode_q       <= ttt_pkg::MODE_WAIT;
      latest_q     <= '0;
      start_q      <= '0;
      tick_q       <= '0;
      live_valid_q <= 1'b0;
      live_centi_q <= ttt_pkg::CENTI_BASE;
      live_flag_q  <= ttt_pkg::FLAG_OK;
      held_valid_q <= 1'b0;
      held_centi_q <= ttt_pkg::CENTI_BASE;
    end else begin
      if (cfg_i.we && cfg_i.index == ttt_pkg::REG_INTERVAL) begin
        interval_q <= cfg_i.data[ttt_pkg::TICK_BITS-1:0];
      end
      if (cfg_i.we && cfg_i.index == ttt_pkg::REG_DELTA) begin
        delta_q <= cfg_i.data[ttt_pkg::DELTA_BITS-1:0];
      end
      if (cmd_i.set_latest) latest_q <= sample_q;
      if (cmd_i.enter_measure) begin
        mode_q  <= ttt_pkg::MODE_MEAS;
        start_q <= latest_q;
        tick_q  <= '0;
      end
      if (cmd_i.restart) begin
        start_q <= latest_q;
        tick_q  <= '0;
      end
      if (cmd_i.tick_inc) tick_q <= ttt_pkg::TICK_BITS'(tick_q + 1'b1);
      if (cmd_i.leave_done) begin
        mode_q       <= ttt_pkg::MODE_WAIT;
        live_valid_q <= 1'b0;
        live_centi_q <= ttt_pkg::CENTI_BASE;
        live_flag_q  <= ttt_pkg::FLAG_OK;
      end
      if (cmd_i.commit) begin
        if (tgt_held_q) begin
          held_centi_q <= res_centi;
          held_valid_q <= 1'b1;
          mode_q       <= ttt_pkg::MODE_DONE;
        end else begin
          live_centi_q <= res_centi;
          live_flag_q  <= res_flag;
          live_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      kind_q   <= in_kind_i;
      sample_q <= in_sample_i;
    end
    if (cmd_i.start_live || cmd_i.start_held) begin
      code_q     <= cmd_i.start_live ? sample_q : latest_q;
      tgt_held_q <= cmd_i.start_held;
      idx_q      <= '0;
      centi_q    <= ttt_pkg::CENTI_BASE;
    end
    if (cmd_i.step) begin
      idx_q   <= ttt_pkg::IDX_BITS'(idx_q + 1'b1);
      centi_q <= centi_q + ttt_pkg::CENTI_STEP;
    end
    if (cmd_i.load_out) begin
      out_mode_q       <= mode_q;
      out_live_valid_q <= live_valid_q;
      out_live_centi_q <= live_centi_q;
      out_live_flag_q  <= live_flag_q;
      out_held_valid_q <= held_valid_q;
      out_held_centi_q <= held_centi_q;
    end
  end

  assign mode_o       = out_mode_q;
  assign live_valid_o = out_live_valid_q;
  assign live_centi_o = out_live_centi_q;
  assign live_flag_o  = out_live_flag_q;
  assign held_valid_o = out_held_valid_q;
  assign held_centi_o = out_held_centi_q;

endmodule

/* rtl/thermistor_table_thermometer_unit.sv */
// Top level of the thermistor thermometer: sequencer plus datapath on three channels.
// Depends on ttt_pkg, ttt_if.sv, ttt_ctrl and ttt_datapath.
//
// Usage:
//   in_chan_i   requests: kind (ADC sample, button press, timer tick) and the ADC code.
//   out_chan_o  one result per request: mode, live reading with valid and flag, and the
//               held reading, all as they stand after the request; readings in 0.01 C.
//   cfg_chan_i  register writes, always ready: index 0 interval ticks, index 1 stable
//               delta; other indexes are dropped. Write only while no request is in flight.
// Sequencing:
//   One request at a time. A request that needs no conversion runs the execute and finish
//   states; finish loads the result once the output register frees, and input is taken again.
//   A conversion walks the code table one entry per cycle, so a sample while measuring, or
//   the end of a stable interval, adds a search state up to the first table entry at or
//   below the code, whose index k runs from 0 to 130.
// Reset clears the mode to waiting, blanks both readings and loads the register defaults.
// A stalled receiver holds the result in the output register; one more request is taken
// and worked on meanwhile, then waits until the output register frees.
`timescale 1ns / 1ps

module thermistor_table_thermometer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ttt_in_if.sink    in_chan_i,
  ttt_out_if.source out_chan_o,
  ttt_cfg_if.sink   cfg_chan_i
);

  ttt_pkg::cmd_t    cmd;
  ttt_pkg::status_t status;
  ttt_pkg::cfg_wr_t cfg_wr;

  assign cfg_chan_i.ready = 1'b1;
  assign cfg_wr.we        = cfg_chan_i.valid;
  assign cfg_wr.index     = cfg_chan_i.index;
  assign cfg_wr.data      = cfg_chan_i.data;

  ttt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan_i.valid),
    .in_ready_o  (in_chan_i.ready),
    .out_valid_o (out_chan_o.valid),
    .out_ready_i (out_chan_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ttt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .in_kind_i    (in_chan_i.kind),
    .in_sample_i  (in_chan_i.adc_sample),
    .cmd_i        (cmd),
    .status_o     (status),
    .mode_o       (out_chan_o.mode),
    .live_valid_o (out_chan_o.live_valid),
    .live_centi_o (out_chan_o.live_centi),
    .live_flag_o  (out_chan_o.live_flag),
    .held_valid_o (out_chan_o.held_valid),
    .held_centi_o (out_chan_o.held_centi)
  );

endmodule

/* rtl/ttt_checker.sv */
// Port-level checks of the thermometer unit, bound to the top level.
// Depends on ttt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "thermistor_table_thermometer_unit_macros.svh"

module ttt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [1:0]                     mode_i,
  input logic                           live_valid_i,
  input logic [ttt_pkg::CENTI_BITS-1:0] live_centi_i,
  input logic [1:0]                     live_flag_i,
  input logic                           held_valid_i
);

  logic live_blank;
  logic live_clamped;

  assign live_blank   = (live_centi_i == ttt_pkg::CENTI_BASE) &&
                        (live_flag_i == ttt_pkg::FLAG_OK);
  assign live_clamped = (live_centi_i == ttt_pkg::CENTI_BASE) ||
                        (live_centi_i == ttt_pkg::CENTI_TOP);

  `TTT_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `TTT_ASSERT_NXT(a_one_request, in_valid_i && in_ready_i, !in_ready_i)
  `TTT_ASSERT_IMP(a_blank_live, out_valid_i && !live_valid_i, live_blank)
  `TTT_ASSERT_IMP(a_clamp_value, out_valid_i && live_flag_i != ttt_pkg::FLAG_OK, live_clamped)
  `TTT_ASSERT_IMP(a_done_held, out_valid_i && mode_i == ttt_pkg::MODE_DONE, held_valid_i)

endmodule

bind thermistor_table_thermometer_unit ttt_checker u_ttt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_chan_i.valid),
  .in_ready_i   (in_chan_i.ready),
  .out_valid_i  (out_chan_o.valid),
  .out_ready_i  (out_chan_o.ready),
  .mode_i       (out_chan_o.mode),
  .live_valid_i (out_chan_o.live_valid),
  .live_centi_i (out_chan_o.live_centi),
  .live_flag_i  (out_chan_o.live_flag),
  .held_valid_i (out_chan_o.held_valid)
);
